### sv/dac_level_walk_lookup_core_defines.svh
// ----------------------------------------------------------------------------
// DAC level walk lookup - assertion macros
// Shared property wrappers for the lookup core checks.
// ----------------------------------------------------------------------------
`ifndef DAC_LEVEL_WALK_LOOKUP_CORE_DEFINES_SVH
`define DAC_LEVEL_WALK_LOOKUP_CORE_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define DLW_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dlw check failed");

// antecedent holds -> consequent holds in the next cycle
`define DLW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dlw check failed");

`endif

### sv/dlw_pkg.sv
// ----------------------------------------------------------------------------
// dlw_pkg
// Types and constants shared by the DAC level walk lookup modules.
// ----------------------------------------------------------------------------
package dlw_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int MAX_LEVELS_DEF  = 8;

    // marks are kept 32 to a memory word
    localparam int MARK_W  = 32;
    localparam int MARK_WB = 5;

    localparam int POS_W   = 13;
    localparam int SYM_W   = 8;
    localparam int LSEL_W  = 3;
    localparam int START_W = 12;
    localparam int BASE_W  = 13;
    localparam int LC_W    = 4;

    localparam logic [1:0] OP_WR_SYM  = 2'd0;
    localparam logic [1:0] OP_WR_LVL  = 2'd1;
    localparam logic [1:0] OP_ACCESS  = 2'd2;
    localparam logic [1:0] OP_STEP    = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MWR,
        ST_QRD,
        ST_QWAIT,
        ST_DECIDE,
        ST_RANK,
        ST_NEXT,
        ST_FIN,
        ST_ERR
    } dlw_state_t;

    typedef struct packed {
        logic               clr;
        logic               add;
        logic               mask_en;
        logic [MARK_WB-1:0] bit_sel;
    } rank_ctl_t;

endpackage

### sv/dlw_ram.sv
// ----------------------------------------------------------------------------
// dlw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dlw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/dlw_rank_acc.sv
// ----------------------------------------------------------------------------
// dlw_rank_acc
// Rank accumulator: adds the popcount of one mark word per cycle while add is set.
// ----------------------------------------------------------------------------
module dlw_rank_acc
    import dlw_pkg::*;
#(
    parameter int CNT_W = 13
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rank_ctl_t         ctl,
    input  logic [MARK_W-1:0] word,
    output logic [CNT_W-1:0]  count
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MARK_W-1:0] masked;
    logic [MARK_WB:0]  pop;

    always_comb begin
        // last word: keep bits 0..bit_sel inclusive
        masked = ctl.mask_en ? (word & ({MARK_W{1'b1}} >> (MARK_W - 1 - int'(ctl.bit_sel))))
                             : word;
        pop = '0;
        for (int i = 0; i < MARK_W; i++) begin
            pop = pop + (MARK_WB + 1)'(masked[i]);
        end
        count_next = count_reg;
        if (ctl.clr) begin
            count_next = '0;
        end else if (ctl.add) begin
            count_next = count_reg + CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

### sv/dac_level_walk_lookup_core.sv
// ----------------------------------------------------------------------------
// dac_level_walk_lookup_core
// Directly Addressable Codes lookup: symbol/mark stores, level tables, walk.
// ----------------------------------------------------------------------------
// Writes: a level entry is stored on accept; a symbol write also patches its
// mark bit by read-modify-write. A query reads a level in QRD, QWAIT, DECIDE;
// each descent adds RANK over each 32-mark word up to and including the current
// index (128 words at a 4096 store), then NEXT and FIN. One item in flight;
// results leave through a one-entry register. After reset a clearing pass zeroes
// the marks; no item is accepted until it ends. Level count resets to 1.
module dac_level_walk_lookup_core
    import dlw_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // position[12:0] symbol_in[20:13] more_mark[21] level_sel[24:22]
    // start_in[36:25] rank_base_in[49:37] zero[55:50]
    input  logic [55:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_out[7:0] level_out[10:8] next_position[23:11] has_next[24] zero[31:25]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    // error[0]
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

`include "dac_level_walk_lookup_core_defines.svh"

    localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int NW     = (STORE_DEPTH + MARK_W - 1) / MARK_W;
    localparam int WA_W   = (NW > 1) ? $clog2(NW) : 1;
    localparam int CNT_W  = ($clog2(STORE_DEPTH + 1) > 13) ? $clog2(STORE_DEPTH + 1) : 13;
    localparam int SUM_W  = CNT_W + 2;
    localparam int LV_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LC_LIM = (MAX_LEVELS < 8) ? MAX_LEVELS : 8;

    // input fields
    logic [POS_W-1:0]   in_pos;
    logic [SYM_W-1:0]   in_sym;
    logic               in_mark;
    logic [LSEL_W-1:0]  in_lsel;
    logic [START_W-1:0] in_start;
    logic [BASE_W-1:0]  in_base;
    logic [1:0]         in_op;

    assign in_pos   = s_tdata[12:0];
    assign in_sym   = s_tdata[20:13];
    assign in_mark  = s_tdata[21];
    assign in_lsel  = s_tdata[24:22];
    assign in_start = s_tdata[36:25];
    assign in_base  = s_tdata[49:37];
    assign in_op    = s_tuser;

    dlw_state_t state_reg, state_next;

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [LSEL_W-1:0]       lvl_reg, lvl_next;
    logic [1:0]              op_reg, op_next;
    logic                    mark_reg, mark_next;
    logic [SYM_W-1:0]        sym_reg, sym_next;
    logic [WA_W-1:0]         wcnt_reg, wcnt_next;
    logic signed [SUM_W-1:0] nxt_reg, nxt_next;
    logic [LC_W-1:0]         lc_reg;

    logic [START_W-1:0] lvl_start [MAX_LEVELS];
    logic [BASE_W-1:0]  lvl_base  [MAX_LEVELS];

    // output register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic        m_tuser_reg;

    logic              emit;
    logic [SYM_W-1:0]  o_byte;
    logic [LSEL_W-1:0] o_lvl;
    logic [POS_W-1:0]  o_nx;
    logic              o_hn;
    logic              o_last;
    logic              o_err;

    // memory ports
    logic              sym_we;
    logic [SYM_W-1:0]  sym_rdata;
    logic              mk_we;
    logic [WA_W-1:0]   mk_waddr, mk_raddr;
    logic [MARK_W-1:0] mk_wdata, mk_rdata;

    rank_ctl_t        rctl;
    logic [CNT_W-1:0] rank_cnt;

    logic [LC_W-1:0]   lc_eff;
    logic [LC_W-1:0]   lvl1;
    logic              out_free;
    logic              accept;
    logic              bad_pos;
    logic              nx_ok;
    logic [WA_W-1:0]   wlast;
    logic [MARK_WB-1:0] bsel;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign bad_pos   = (in_pos == '0) || ({19'd0, in_pos} > 32'(STORE_DEPTH));
    assign lvl1      = LC_W'(lvl_reg) + LC_W'(1);
    assign wlast     = WA_W'(idx_reg >> MARK_WB);
    assign bsel      = MARK_WB'(idx_reg);
    assign nx_ok     = (nxt_reg >= SUM_W'(1)) && (nxt_reg <= SUM_W'(STORE_DEPTH));

    always_comb begin
        lc_eff = lc_reg;
        if (lc_reg == '0) begin
            lc_eff = LC_W'(1);
        end else if (lc_reg > LC_W'(LC_LIM)) begin
            lc_eff = LC_W'(LC_LIM);
        end
    end

    dlw_ram #(
        .DATA_W (SYM_W),
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_sym_ram (
        .aclk  (aclk),
        .we    (sym_we),
        .waddr (IDX_W'(in_pos)),
        .wdata (in_sym),
        .raddr (idx_reg),
        .rdata (sym_rdata)
    );

    dlw_ram #(
        .DATA_W (MARK_W),
        .DEPTH  (NW),
        .ADDR_W (WA_W)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (mk_we),
        .waddr (mk_waddr),
        .wdata (mk_wdata),
        .raddr (mk_raddr),
        .rdata (mk_rdata)
    );

    dlw_rank_acc #(
        .CNT_W (CNT_W)
    ) u_rank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rctl),
        .word    (mk_rdata),
        .count   (rank_cnt)
    );

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        lvl_next   = lvl_reg;
        op_next    = op_reg;
        mark_next  = mark_reg;
        sym_next   = sym_reg;
        wcnt_next  = wcnt_reg;
        nxt_next   = nxt_reg;
        emit       = 1'b0;
        o_byte     = '0;
        o_lvl      = '0;
        o_nx       = '0;
        o_hn       = 1'b0;
        o_last     = 1'b1;
        o_err      = 1'b0;
        sym_we     = 1'b0;
        mk_we      = 1'b0;
        mk_waddr   = wlast;
        mk_wdata   = mk_rdata;
        mk_raddr   = wlast;
        rctl       = '{clr: 1'b0, add: 1'b0, mask_en: 1'b0, bit_sel: bsel};

        unique case (state_reg)
            ST_CLEAR: begin
                mk_we     = 1'b1;
                mk_waddr  = wcnt_reg;
                mk_wdata  = '0;
                wcnt_next = wcnt_reg + WA_W'(1);
                if (wcnt_reg == WA_W'(NW - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                mk_raddr = WA_W'(in_pos >> MARK_WB);
                if (accept) begin
                    op_next = in_op;
                    unique case (in_op)
                        OP_WR_SYM: begin
                            if ({19'd0, in_pos} < 32'(STORE_DEPTH)) begin
                                sym_we     = 1'b1;
                                idx_next   = IDX_W'(in_pos);
                                mark_next  = in_mark;
                                state_next = ST_MWR;
                            end
                        end
                        OP_WR_LVL: begin
                        end
                        OP_ACCESS, OP_STEP: begin
                            if (bad_pos) begin
                                state_next = ST_ERR;
                            end else begin
                                idx_next   = IDX_W'(in_pos - POS_W'(1));
                                lvl_next   = (in_op == OP_ACCESS) ? '0 : in_lsel;
                                state_next = ST_QRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MWR: begin
                // read data of the word came back; patch one bit and write
                mk_we           = 1'b1;
                mk_wdata        = mk_rdata;
                mk_wdata[bsel]  = mark_reg;
                state_next      = ST_IDLE;
            end
            ST_QRD: begin
                state_next = ST_QWAIT;
            end
            ST_QWAIT: begin
                sym_next   = sym_rdata;
                mark_next  = mk_rdata[bsel];
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                mk_raddr = '0;
                if (op_reg == OP_ACCESS) begin
                    if (out_free) begin
                        emit   = 1'b1;
                        o_byte = sym_reg;
                        o_lvl  = lvl_reg;
                        if (mark_reg && (lvl1 < lc_eff)) begin
                            o_last     = 1'b0;
                            rctl.clr   = 1'b1;
                            wcnt_next  = '0;
                            state_next = ST_RANK;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    if (mark_reg && (lvl1 < lc_eff)) begin
                        rctl.clr   = 1'b1;
                        wcnt_next  = '0;
                        state_next = ST_RANK;
                    end else if (out_free) begin
                        emit       = 1'b1;
                        o_byte     = sym_reg;
                        o_lvl      = lvl_reg;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RANK: begin
                rctl.add     = 1'b1;
                rctl.mask_en = (wcnt_reg == wlast);
                mk_raddr     = wcnt_reg + WA_W'(1);
                if (wcnt_reg == wlast) begin
                    state_next = ST_NEXT;
                end else begin
                    wcnt_next = wcnt_reg + WA_W'(1);
                end
            end
            ST_NEXT: begin
                // 1-based position in the next level
                nxt_next = SUM_W'(lvl_start[LV_W'(lvl1)]) + SUM_W'(rank_cnt)
                         - SUM_W'(lvl_base[LV_W'(lvl_reg)]);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (op_reg == OP_ACCESS) begin
                    if (nx_ok) begin
                        idx_next   = IDX_W'(nxt_reg - SUM_W'(1));
                        lvl_next   = LSEL_W'(lvl1);
                        state_next = ST_QRD;
                    end else if (out_free) begin
                        emit       = 1'b1;
                        o_lvl      = LSEL_W'(lvl1);
                        o_err      = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (out_free) begin
                    emit   = 1'b1;
                    o_byte = sym_reg;
                    o_lvl  = lvl_reg;
                    if (nx_ok && (nxt_reg <= SUM_W'(8191))) begin
                        o_nx = POS_W'(nxt_reg);
                        o_hn = 1'b1;
                    end else begin
                        o_err = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    emit       = 1'b1;
                    o_err      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            wcnt_reg     <= '0;
            lc_reg       <= LC_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wcnt_reg  <= wcnt_next;
            if (cfg_valid && cfg_ready) begin
                lc_reg <= cfg_data;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        lvl_reg  <= lvl_next;
        op_reg   <= op_next;
        mark_reg <= mark_next;
        sym_reg  <= sym_next;
        nxt_reg  <= nxt_next;
        if (emit) begin
            m_tdata_reg <= {7'd0, o_hn, o_nx, o_lvl, o_byte};
            m_tlast_reg <= o_last;
            m_tuser_reg <= o_err;
        end
        if (accept && (in_op == OP_WR_LVL) && ({29'd0, in_lsel} < 32'(MAX_LEVELS))) begin
            lvl_start[LV_W'(in_lsel)] <= in_start;
            lvl_base[LV_W'(in_lsel)]  <= in_base;
        end
    end

    // end-of-item flag travels with the registered result
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `DLW_ASSERT_SAME(a_clear_blocks, aclk, aresetn, state_reg == ST_CLEAR, !s_tready)
    `DLW_ASSERT_SAME(a_emit_slot, aclk, aresetn, emit, out_free)
    `DLW_ASSERT_NEXT(a_bad_query, aclk, aresetn,
                     accept && (in_op == OP_ACCESS || in_op == OP_STEP) && bad_pos,
                     state_reg == ST_ERR)
    `DLW_ASSERT_SAME(a_rank_bound, aclk, aresetn, state_reg == ST_RANK, wcnt_reg <= wlast)

endmodule
